// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: field widths, default arena
// geometry and the response status codes. No dependencies.
package ffha_pkg;

   // Widths of the item fields on the request and response channels.
   localparam int FIELD_W  = 16;
   localparam int STATUS_W = 3;

   // Default arena geometry, handed to the top-level parameters.
   localparam int DEFAULT_HEAP_BYTES   = 65536;
   localparam int DEFAULT_HEADER_BYTES = 24;

   // Payload sizes are rounded up to this granule, and one header entry
   // covers one granule of the arena.
   localparam int ALIGN_BYTES = 8;
   localparam int ALIGN_SHIFT = 3;

   // Request action codes.
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NULL_FREE = 3'd4;

endpackage

// ===== rtl/ffha_if.sv =====
// Valid/ready channel interfaces for the heap allocator's request and
// response items. Depends on ffha_pkg for the field widths.
interface ffha_req_if;
   import ffha_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [FIELD_W-1:0] size_bytes;
   logic [FIELD_W-1:0] address;

   modport source (output valid, output action, output size_bytes, output address,
                   input ready);
   modport sink   (input valid, input action, input size_bytes, input address,
                   output ready);
endinterface

interface ffha_rsp_if;
   import ffha_pkg::*;

   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  result_address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output result_address, output status, input ready);
   modport sink   (input valid, input result_address, input status, output ready);
endinterface

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator over one contiguous arena, top level.
// Depends on ffha_pkg, ffha_if.sv (channel interfaces) and ffha_ram.
//
// Usage: a request item on req_ch either allocates size_bytes (action 0)
// or frees the payload at address (action 1). Each request yields exactly
// one response item on rsp_ch with the payload address and a status.
// Blocks lie back to back from offset 0; each block's header (payload size
// and a free mark) sits in one RAM entry per 8-byte granule of the arena.
//
// Headers are walked one block at a time through the one RAM read port. An
// allocate walks up to the first free block that fits, else over all blocks
// and then tries the append. A free searches for its block, then runs a merge
// pass over all blocks however many merge; a rejected free ends with its
// search. A zero-size allocate or a null free answers without a walk. One
// request is in work at a time; req_ch is ready only while the unit is idle.
//
// Reset clears the arena (heap top back to 0); the header RAM needs no
// clearing since only headers that were written are ever read. If the
// response receiver stalls, the finished item waits in the output
// register and the unit holds its next result until that item is taken.
module first_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES   = ffha_pkg::DEFAULT_HEAP_BYTES,
   parameter int HEADER_BYTES = ffha_pkg::DEFAULT_HEADER_BYTES
) (
   input  logic  clock,
   input  logic  reset,
   ffha_req_if.sink   req_ch,
   ffha_rsp_if.source rsp_ch
);
   import ffha_pkg::*;

   // Arena geometry.
   localparam int SLOTS   = HEAP_BYTES / ALIGN_BYTES;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SIZE_W  = $clog2(HEAP_BYTES);
   localparam int ENTRY_W = SIZE_W + 1;
   localparam int POS_W   = $clog2(HEAP_BYTES + 1);
   localparam int NEED_W  = FIELD_W + 1;
   localparam int CMP_W   = ((POS_W > NEED_W) ? POS_W : NEED_W) + 2;

   localparam logic [CMP_W-1:0] HDR_C   = CMP_W'(HEADER_BYTES);
   localparam logic [CMP_W-1:0] SPLIT_C = CMP_W'(HEADER_BYTES + ALIGN_BYTES);
   localparam logic [CMP_W-1:0] HEAP_C  = CMP_W'(HEAP_BYTES);
   localparam logic [NEED_W-1:0] ROUND_C = NEED_W'(ALIGN_BYTES - 1);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_A_RD    = 12'b0000_0000_0010,
      ST_A_CHK   = 12'b0000_0000_0100,
      ST_A_SPLIT = 12'b0000_0000_1000,
      ST_A_APP   = 12'b0000_0001_0000,
      ST_F_RD    = 12'b0000_0010_0000,
      ST_F_CHK   = 12'b0000_0100_0000,
      ST_M_START = 12'b0000_1000_0000,
      ST_M_LOAD  = 12'b0001_0000_0000,
      ST_M_NEXT  = 12'b0010_0000_0000,
      ST_M_CHK   = 12'b0100_0000_0000,
      ST_RESP    = 12'b1000_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [FIELD_W-1:0]  addr_ff, addr_in;
   logic [POS_W-1:0]    cur_ff, cur_in;
   logic [POS_W-1:0]    nxt_ff, nxt_in;
   logic [ENTRY_W-1:0]  hdr_ff, hdr_in;
   logic [POS_W-1:0]    heap_top_ff, heap_top_in;
   logic [FIELD_W-1:0]  res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Header RAM ports.
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

   // Fields of the header just read and of the held header.
   logic [SIZE_W-1:0] rd_size, hold_size;
   logic              rd_free, hold_free;
   logic [CMP_W-1:0]  cur_w, top_w, need_w, addr_w, payload_w;
   logic [CMP_W-1:0]  rd_next_w, hold_next_w, rest_w, app_end_w, merged_w;
   logic [CMP_W-1:0]  app_payload_w;
   logic              req_fire, rsp_fire;

   assign rd_size   = mem_rdata[SIZE_W-1:0];
   assign rd_free   = mem_rdata[SIZE_W];
   assign hold_size = hdr_ff[SIZE_W-1:0];
   assign hold_free = hdr_ff[SIZE_W];

   assign cur_w         = CMP_W'(cur_ff);
   assign top_w         = CMP_W'(heap_top_ff);
   assign need_w        = CMP_W'(need_ff);
   assign addr_w        = CMP_W'(addr_ff);
   assign payload_w     = cur_w + HDR_C;
   assign rd_next_w     = payload_w + CMP_W'(rd_size);
   assign hold_next_w   = payload_w + CMP_W'(hold_size);
   assign rest_w        = payload_w + need_w;
   assign app_payload_w = top_w + HDR_C;
   assign app_end_w     = top_w + HDR_C + need_w;
   assign merged_w      = CMP_W'(hold_size) + HDR_C + CMP_W'(rd_size);

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.status         = rsp_status_ff;

   ffha_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_hdr_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Sequencer: header walk, split, append, free and merge pass.
   always_comb begin
      state_in      = state_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      hdr_in        = hdr_ff;
      heap_top_in   = heap_top_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff[IDX_W+ALIGN_SHIFT-1:ALIGN_SHIFT];
      mem_wdata     = hdr_ff;
      mem_re        = 1'b0;
      mem_raddr     = cur_ff[IDX_W+ALIGN_SHIFT-1:ALIGN_SHIFT];

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in      = '0;
               addr_in     = req_ch.address;
               need_in     = (NEED_W'(req_ch.size_bytes) + ROUND_C) & ~ROUND_C;
               res_addr_in = '0;
               if (req_ch.action == ACTION_FREE) begin
                  if (req_ch.address == '0) begin
                     res_status_in = STATUS_NULL_FREE;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_F_RD;
                  end
               end else begin
                  if (req_ch.size_bytes == '0) begin
                     res_status_in = STATUS_ZERO_SIZE;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_A_RD;
                  end
               end
            end
         end

         // Allocate: read the next header, or fall through to the append.
         ST_A_RD: begin
            if (cur_w < top_w) begin
               mem_re   = 1'b1;
               state_in = ST_A_CHK;
            end else begin
               state_in = ST_A_APP;
            end
         end

         // Allocate: take the first free block that fits, splitting if the
         // remainder can hold a header and one granule.
         ST_A_CHK: begin
            if (rd_free && (CMP_W'(rd_size) >= need_w)) begin
               res_addr_in   = payload_w[FIELD_W-1:0];
               res_status_in = STATUS_OK;
               mem_we        = 1'b1;
               if (CMP_W'(rd_size) >= need_w + SPLIT_C) begin
                  mem_waddr = rest_w[IDX_W+ALIGN_SHIFT-1:ALIGN_SHIFT];
                  mem_wdata = {1'b1, SIZE_W'(CMP_W'(rd_size) - need_w - HDR_C)};
                  state_in  = ST_A_SPLIT;
               end else begin
                  mem_wdata = {1'b0, rd_size};
                  state_in  = ST_RESP;
               end
            end else begin
               cur_in   = rd_next_w[POS_W-1:0];
               state_in = ST_A_RD;
            end
         end

         ST_A_SPLIT: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, need_ff[SIZE_W-1:0]};
            state_in  = ST_RESP;
         end

         // Allocate: no fit, so append a block at the top if there is room.
         ST_A_APP: begin
            if (app_end_w > HEAP_C) begin
               res_status_in = STATUS_NO_SPACE;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = heap_top_ff[IDX_W+ALIGN_SHIFT-1:ALIGN_SHIFT];
               mem_wdata     = {1'b0, need_ff[SIZE_W-1:0]};
               heap_top_in   = app_end_w[POS_W-1:0];
               res_addr_in   = app_payload_w[FIELD_W-1:0];
               res_status_in = STATUS_OK;
            end
            state_in = ST_RESP;
         end

         // Free: walk to the block whose payload address matches.
         ST_F_RD: begin
            if (cur_w < top_w) begin
               mem_re   = 1'b1;
               state_in = ST_F_CHK;
            end else begin
               res_status_in = STATUS_BAD_FREE;
               state_in      = ST_RESP;
            end
         end

         ST_F_CHK: begin
            if (payload_w == addr_w) begin
               if (rd_free) begin
                  res_status_in = STATUS_BAD_FREE;
                  state_in      = ST_RESP;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = {1'b1, rd_size};
                  state_in  = ST_M_START;
               end
            end else if (payload_w > addr_w) begin
               res_status_in = STATUS_BAD_FREE;
               state_in      = ST_RESP;
            end else begin
               cur_in   = rd_next_w[POS_W-1:0];
               state_in = ST_F_RD;
            end
         end

         // Merge pass: start again at the bottom of the arena.
         ST_M_START: begin
            cur_in    = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = ST_M_LOAD;
         end

         ST_M_LOAD: begin
            hdr_in   = mem_rdata;
            state_in = ST_M_NEXT;
         end

         // Merge pass: read the neighbor of the held header, or finish.
         ST_M_NEXT: begin
            if (hold_next_w >= top_w) begin
               res_status_in = STATUS_OK;
               state_in      = ST_RESP;
            end else begin
               nxt_in    = hold_next_w[POS_W-1:0];
               mem_re    = 1'b1;
               mem_raddr = hold_next_w[IDX_W+ALIGN_SHIFT-1:ALIGN_SHIFT];
               state_in  = ST_M_CHK;
            end
         end

         // Merge pass: fold a free neighbor into the held block, else step.
         ST_M_CHK: begin
            if (hold_free && rd_free) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, merged_w[SIZE_W-1:0]};
               hdr_in    = {1'b1, merged_w[SIZE_W-1:0]};
            end else begin
               cur_in = nxt_ff;
               hdr_in = mem_rdata;
            end
            state_in = ST_M_NEXT;
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         heap_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_top_ff  <= heap_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      hdr_ff        <= hdr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The header RAM is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(mem_we && mem_re))
      else $error("header RAM read and write overlap");

   // The arena top never passes the end of the arena.
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(heap_top_ff) <= HEAP_C)
      else $error("heap top beyond arena");

   // An accepted request always starts work.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted request was dropped");

   // A failed or rejected request reports a null address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_addr_ff == '0)
      else $error("non-zero address on failed request");

   // The top only moves while an allocate appends a block.
   assert property (@(posedge clock) disable iff (reset)
      heap_top_ff != $past(heap_top_ff) |-> $past(state_ff) == ST_A_APP)
      else $error("heap top changed outside an append");

endmodule

// ===== rtl/ffha_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module ffha_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== dv/first_fit_heap_allocator_unit_tb.sv =====
// Self-checking testbench for first_fit_heap_allocator_unit: directed corner
// requests, then random allocate/free traffic checked against an arena model.
// Depends on ffha_pkg and the channel interfaces in ffha_if.sv.
module first_fit_heap_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ffha_pkg::*;

   localparam int CLK_PERIOD      = 4;
   localparam int RESET_CYCLES    = 12;
   localparam int HEAP_BYTES      = DEFAULT_HEAP_BYTES;
   localparam int HEADER_BYTES    = DEFAULT_HEADER_BYTES;
   localparam int HEAP_SLOTS      = HEAP_BYTES / ALIGN_BYTES;
   localparam int BUSY_ITEMS      = 1420;
   localparam int QUIET_ITEMS     = 200;
   localparam int LIVE_CAP        = 120;
   localparam int RELEASED_DEPTH  = 16;
   localparam int DRAIN_CYCLES    = 64;
   localparam int WATCHDOG_CYCLES = 20000;

   // One response item as the arena model predicts it.
   typedef struct packed {
      logic [FIELD_W-1:0]  result_address;
      logic [STATUS_W-1:0] status;
   } heap_reply_type;

   logic clock;
   logic reset;

   ffha_req_if req_ch ();
   ffha_rsp_if rsp_ch ();

   first_fit_heap_allocator_unit #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Arena model: one header per 8-byte granule, plus the arena top.
   int unsigned hdr_size [HEAP_SLOTS];
   bit          hdr_free [HEAP_SLOTS];
   int unsigned arena_top;

   heap_reply_type pending_replies[$];
   int unsigned live_payloads[$];
   int unsigned released_payloads[$];

   int  mismatch_count;
   int  stall_cycles;
   int  src_gap_pct;
   int  sink_stall_pct;
   bit  quiet_phase;

   // Free-running clock.
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned next_block(int unsigned start);
      return start + HEADER_BYTES + hdr_size[start >> ALIGN_SHIFT];
   endfunction

   // Fold every run of adjacent free blocks into its first block.
   function automatic void merge_free_runs();
      int unsigned cur;
      int unsigned nxt;
      cur = 0;
      while (cur < arena_top) begin
         nxt = next_block(cur);
         if (nxt >= arena_top)
            break;
         if (hdr_free[cur >> ALIGN_SHIFT] && hdr_free[nxt >> ALIGN_SHIFT])
            hdr_size[cur >> ALIGN_SHIFT] = hdr_size[cur >> ALIGN_SHIFT] + HEADER_BYTES
                                           + hdr_size[nxt >> ALIGN_SHIFT];
         else
            cur = nxt;
      end
   endfunction

   // First-fit allocate: reuse a free block (splitting it when the rest can
   // hold a header and one granule), else append at the arena top.
   function automatic heap_reply_type predict_allocate(int unsigned size_bytes);
      heap_reply_type reply;
      int unsigned need;
      int unsigned cur;
      int unsigned have;
      int unsigned rest;
      reply.result_address = '0;
      if (size_bytes == 0) begin
         reply.status = STATUS_ZERO_SIZE;
         return reply;
      end
      need = ((size_bytes + ALIGN_BYTES - 1) >> ALIGN_SHIFT) << ALIGN_SHIFT;
      cur = 0;
      while (cur < arena_top) begin
         have = hdr_size[cur >> ALIGN_SHIFT];
         if (hdr_free[cur >> ALIGN_SHIFT] && have >= need) begin
            if (have >= need + HEADER_BYTES + ALIGN_BYTES) begin
               rest = cur + HEADER_BYTES + need;
               hdr_size[rest >> ALIGN_SHIFT] = have - need - HEADER_BYTES;
               hdr_free[rest >> ALIGN_SHIFT] = 1'b1;
               hdr_size[cur >> ALIGN_SHIFT]  = need;
            end
            hdr_free[cur >> ALIGN_SHIFT] = 1'b0;
            reply.result_address = FIELD_W'(cur + HEADER_BYTES);
            reply.status         = STATUS_OK;
            return reply;
         end
         cur = next_block(cur);
      end
      if (HEAP_BYTES - arena_top < HEADER_BYTES ||
          HEAP_BYTES - arena_top - HEADER_BYTES < need) begin
         reply.status = STATUS_NO_SPACE;
         return reply;
      end
      cur = arena_top;
      hdr_size[cur >> ALIGN_SHIFT] = need;
      hdr_free[cur >> ALIGN_SHIFT] = 1'b0;
      arena_top = cur + HEADER_BYTES + need;
      reply.result_address = FIELD_W'(cur + HEADER_BYTES);
      reply.status         = STATUS_OK;
      return reply;
   endfunction

   // Free: the address must be the payload of a block in use.
   function automatic heap_reply_type predict_release(int unsigned address);
      heap_reply_type reply;
      int unsigned cur;
      reply.result_address = '0;
      if (address == 0) begin
         reply.status = STATUS_NULL_FREE;
         return reply;
      end
      reply.status = STATUS_BAD_FREE;
      cur = 0;
      while (cur < arena_top) begin
         if (cur + HEADER_BYTES == address) begin
            if (!hdr_free[cur >> ALIGN_SHIFT]) begin
               hdr_free[cur >> ALIGN_SHIFT] = 1'b1;
               merge_free_runs();
               reply.status = STATUS_OK;
            end
            return reply;
         end
         if (cur + HEADER_BYTES > address)
            break;
         cur = next_block(cur);
      end
      return reply;
   endfunction

   // Send one request item, with an optional gap before it, then predict
   // its reply and keep track of which payloads are live.
   task automatic send_request(input logic action, input logic [FIELD_W-1:0] size_bytes,
                               input logic [FIELD_W-1:0] address,
                               output heap_reply_type predicted);
      int gap;
      int idx;
      if (!quiet_phase && $urandom_range(0, 99) < src_gap_pct) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.action     = action;
      req_ch.size_bytes = size_bytes;
      req_ch.address    = address;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);

      if (action == ACTION_ALLOC)
         predicted = predict_allocate(32'(size_bytes));
      else
         predicted = predict_release(32'(address));
      pending_replies.push_back(predicted);

      if (predicted.status == STATUS_OK) begin
         if (action == ACTION_ALLOC) begin
            live_payloads.push_back(32'(predicted.result_address));
         end else begin
            for (idx = 0; idx < live_payloads.size(); idx++) begin
               if (live_payloads[idx] == 32'(address)) begin
                  live_payloads.delete(idx);
                  break;
               end
            end
            released_payloads.push_back(32'(address));
            if (released_payloads.size() > RELEASED_DEPTH)
               void'(released_payloads.pop_front());
         end
      end
   endtask

   // Zero sizes, null and unknown frees on an empty arena, and an
   // allocate too large for the whole arena.
   task automatic test_trivial_requests();
      heap_reply_type reply;
      send_request(ACTION_ALLOC, 16'd0, 16'd0, reply);
      send_request(ACTION_FREE, 16'd0, 16'd0, reply);
      send_request(ACTION_FREE, 16'd0, 16'(HEADER_BYTES), reply);
      send_request(ACTION_ALLOC, 16'hFFFF, 16'd0, reply);
      send_request(ACTION_FREE, 16'hFFFF, 16'hFFFF, reply);
   endtask

   // Split at the exact boundary, reuse without a split, double free, a
   // free inside a block, and an append when nothing free fits.
   task automatic test_split_boundaries();
      heap_reply_type reply;
      logic [FIELD_W-1:0] wide_payload;
      send_request(ACTION_ALLOC, 16'd1, 16'd0, reply);
      send_request(ACTION_ALLOC, 16'd200, 16'd0, reply);
      wide_payload = reply.result_address;
      send_request(ACTION_ALLOC, 16'd16, 16'd0, reply);
      send_request(ACTION_FREE, 16'd0, wide_payload, reply);
      send_request(ACTION_FREE, 16'd0, wide_payload, reply);
      send_request(ACTION_FREE, 16'd0, wide_payload + 16'd8, reply);
      // The remainder is exactly one header plus one granule.
      send_request(ACTION_ALLOC, 16'd168, 16'd0, reply);
      send_request(ACTION_ALLOC, 16'd8, 16'd0, reply);
      send_request(ACTION_FREE, 16'd0, wide_payload, reply);
      // Fits, but the rest is too small to split off.
      send_request(ACTION_ALLOC, 16'd160, 16'd0, reply);
      send_request(ACTION_ALLOC, 16'd176, 16'd0, reply);
   endtask

   // A free block at the top is not grown by an append; freeing the new
   // block merges the two. Then sizes with alternating bit patterns.
   task automatic test_tail_and_merge();
      heap_reply_type reply;
      logic [FIELD_W-1:0] tail_payload;
      logic [FIELD_W-1:0] pattern_payload;
      send_request(ACTION_ALLOC, 16'd1000, 16'd0, reply);
      tail_payload = reply.result_address;
      send_request(ACTION_FREE, 16'd0, tail_payload, reply);
      send_request(ACTION_ALLOC, 16'd2000, 16'd0, reply);
      send_request(ACTION_FREE, 16'd0, reply.result_address, reply);
      send_request(ACTION_ALLOC, 16'h5555, 16'd0, reply);
      pattern_payload = reply.result_address;
      send_request(ACTION_ALLOC, 16'hAAAA, 16'd0, reply);
      send_request(ACTION_FREE, 16'd0, pattern_payload, reply);
   endtask

   // Random mix of well-formed allocate/free traffic, malformed frees and zero-size allocates.
   task automatic test_random_traffic(input int item_count);
      heap_reply_type reply;
      int done;
      int pick;
      int unsigned size_bytes;
      int unsigned address;
      done = 0;
      while (done < item_count) begin
         if (done % 40 == 0) begin
            src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
         end
         pick = $urandom_range(0, 99);
         if (pick >= 52 && pick < 94 && live_payloads.size() == 0)
            pick = 0;
         if (pick < 52 && live_payloads.size() >= LIVE_CAP)
            pick = 60;
         if (pick < 52) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
               size_bytes = $urandom_range(1, 64);
            else if (pick < 75)
               size_bytes = $urandom_range(1, 1024);
            else if (pick < 96)
               size_bytes = $urandom_range(1025, 4096);
            else
               size_bytes = $urandom_range(1, 65535);
            send_request(ACTION_ALLOC, 16'(size_bytes), 16'($urandom), reply);
            done++;
         end else if (pick < 85) begin
            address = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
            send_request(ACTION_FREE, 16'($urandom), 16'(address), reply);
            done++;
         end else if (pick < 90 && released_payloads.size() != 0) begin
            // Often a double free, unless the block was handed out again.
            address = released_payloads[$urandom_range(0, released_payloads.size() - 1)];
            send_request(ACTION_FREE, 16'($urandom), 16'(address), reply);
            done++;
         end else if (pick < 94) begin
            address = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
            if ($urandom_range(0, 1) == 0)
               address = address + ALIGN_BYTES * $urandom_range(1, 4);
            else
               address = address - ALIGN_BYTES;
            send_request(ACTION_FREE, 16'($urandom), 16'(address), reply);
            done++;
         end else if (pick < 97) begin
            send_request(ACTION_FREE, 16'($urandom), 16'($urandom_range(1, 65535)), reply);
            done++;
         end else if (pick < 98) begin
            send_request(ACTION_FREE, 16'($urandom), 16'd0, reply);
         end else begin
            send_request(ACTION_ALLOC, 16'd0, 16'($urandom), reply);
         end
      end
   endtask

   // Response sink: ready in random stretches, with stall bursts.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 99) < sink_stall_pct) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 20) - 1) @(negedge clock);
         end
      end
   end

   // Compare each response item with the oldest prediction, and stop the
   // run if no item moves on either channel for too long.
   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no item, got addr %0d status %0d", $time,
                        rsp_ch.result_address, rsp_ch.status);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.result_address !== want.result_address) begin
                  mismatch_count++;
                  $display("%0t: result_address expected %0d, got %0d", $time,
                           want.result_address, rsp_ch.result_address);
               end
               if (rsp_ch.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d, got %0d", $time,
                           want.status, rsp_ch.status);
               end
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      mismatch_count    = 0;
      stall_cycles      = 0;
      src_gap_pct       = 20;
      sink_stall_pct    = 20;
      quiet_phase       = 1'b0;
      arena_top         = '0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACTION_ALLOC;
      req_ch.size_bytes = '0;
      req_ch.address    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_trivial_requests();
      test_split_boundaries();
      test_tail_and_merge();
      test_random_traffic(BUSY_ITEMS);
      quiet_phase = 1'b1;
      test_random_traffic(QUIET_ITEMS);

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
